[rtl/qrm_pkg.sv]
// Shared types, constants and helpers for the quaternion to rotation matrix unit.
// No dependencies; every other file refers to this package by scoped names.
`default_nettype none
package qrm_pkg;

   localparam int unsigned DataWidth  = 32;
   localparam int unsigned TolWidth   = 31;
   localparam int unsigned MagWidth   = 33;
   localparam int unsigned SqrtSteps  = 32;
   localparam int unsigned SqrtStages = SqrtSteps + 2;
   localparam int unsigned DivSteps   = 31;
   localparam int unsigned DivStages  = DivSteps + 2;
   localparam int unsigned MatStages  = 3;
   localparam int unsigned Lanes      = 4;
   localparam int unsigned Entries    = 9;

   localparam logic [1:0] StatusUnit       = 2'd0;
   localparam logic [1:0] StatusNormalized = 2'd1;
   localparam logic [1:0] StatusZero       = 2'd2;

   localparam logic [MagWidth-1:0]   MagOne   = 33'h0_4000_0000;
   localparam logic [30:0]           QuoOne   = 31'h4000_0000;
   localparam logic signed [64:0]    SumLimit = 65'sh0_2000_0000_0000_0000;
   localparam logic signed [63:0]    DiagBias = 64'sh0800_0000_0000_0000;
   localparam logic signed [63:0]    RndBias  = 64'sh0000_0000_1000_0000;
   localparam logic signed [34:0]    EntryMax = 35'sh0_4000_0000;
   localparam logic signed [34:0]    EntryMin = -35'sh0_4000_0000;

   // lane 0 x, lane 1 y, lane 2 z, lane 3 scalar
   typedef logic [Lanes-1:0][DataWidth-1:0] quat_type;
   typedef logic [Entries-1:0][DataWidth-1:0] matrix_type;

   typedef struct packed {
      logic [35:0] rem;
      logic [31:0] root;
      logic [63:0] rad;
      logic        ovf;
   } root_step_type;

   typedef struct packed {
      logic [32:0] rem;
      logic [30:0] num;
      logic [30:0] quo;
   } div_lane_type;

   function automatic logic [DataWidth-1:0] abs_value(logic [DataWidth-1:0] v);
      return v[DataWidth-1] ? (~v + 32'd1) : v;
   endfunction

endpackage
`default_nettype wire

[rtl/quaternion_to_rotation_matrix_unit.sv]
// Top level of the quaternion to rotation matrix unit: tolerance register and pipeline.
// Depends on qrm_pkg, qrm_sqrt, qrm_divide and qrm_matrix.
//
// Usage:
//   Request channel req_*: quaternion x, y, z, scalar in signed Q1.30, taken at a
//   clock edge with req_valid high and req_stall low.
//   Response channel rsp_*: nine Q1.30 matrix entries and a status (unit input,
//   normalized, zero magnitude), taken with rsp_valid high and rsp_stall low.
//   Config channel csr_*: norm tolerance, written when csr_valid is high;
//   csr_ready is always high. Write it only while no request is in flight.
//   From request to response the pipeline has 34 stages of squares, sum and
//   a one-bit-per-stage square root, 33 stages of status and a one-bit-per-stage
//   divider over four lanes, 3 stages of products, sums and rounding.
//   Throughput is one request per cycle while req_stall is low.
//   Reset clears all stage valid bits and sets the tolerance to zero.
//   When the receiver stalls, the last stage holds its response and earlier
//   stages keep filling empty slots; req_stall rises once no slot is free.
`default_nettype none
module quaternion_to_rotation_matrix_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_quat_x,
   input  logic signed [31:0] req_quat_y,
   input  logic signed [31:0] req_quat_z,
   input  logic signed [31:0] req_quat_scalar,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_m00,
   output logic signed [31:0] rsp_m01,
   output logic signed [31:0] rsp_m02,
   output logic signed [31:0] rsp_m10,
   output logic signed [31:0] rsp_m11,
   output logic signed [31:0] rsp_m12,
   output logic signed [31:0] rsp_m20,
   output logic signed [31:0] rsp_m21,
   output logic signed [31:0] rsp_m22,
   output logic [1:0]         rsp_status,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [30:0]        csr_norm_tolerance
);

   logic [qrm_pkg::TolWidth-1:0] tol_ff;
   qrm_pkg::quat_type            req_quat;
   qrm_pkg::quat_type            root_quat;
   logic [qrm_pkg::MagWidth-1:0] root_mag;
   logic                         root_valid;
   logic                         root_stall;
   qrm_pkg::quat_type            div_quat;
   logic [1:0]                   div_status;
   logic                         div_valid;
   logic                         div_stall;
   qrm_pkg::matrix_type          matrix;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         tol_ff <= csr_norm_tolerance;
      end
   end

   assign req_quat = {req_quat_scalar, req_quat_z, req_quat_y, req_quat_x};

   qrm_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_quat   (req_quat),
      .out_valid (root_valid),
      .out_stall (root_stall),
      .out_quat  (root_quat),
      .out_mag   (root_mag)
   );

   qrm_divide u_divide (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (root_valid),
      .in_stall   (root_stall),
      .in_quat    (root_quat),
      .in_mag     (root_mag),
      .tolerance  (tol_ff),
      .out_valid  (div_valid),
      .out_stall  (div_stall),
      .out_quat   (div_quat),
      .out_status (div_status)
   );

   qrm_matrix u_matrix (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (div_valid),
      .in_stall   (div_stall),
      .in_quat    (div_quat),
      .in_status  (div_status),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .out_matrix (matrix),
      .out_status (rsp_status)
   );

   assign rsp_m00 = matrix[0];
   assign rsp_m01 = matrix[1];
   assign rsp_m02 = matrix[2];
   assign rsp_m10 = matrix[3];
   assign rsp_m11 = matrix[4];
   assign rsp_m12 = matrix[5];
   assign rsp_m20 = matrix[6];
   assign rsp_m21 = matrix[7];
   assign rsp_m22 = matrix[8];

endmodule
`default_nettype wire

[rtl/qrm_sqrt.sv]
// Squares, sum and a one-bit-per-stage integer square root of the quaternion magnitude.
// Depends on qrm_pkg.
`default_nettype none
module qrm_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_stall,
   input  qrm_pkg::quat_type             in_quat,
   output logic                          out_valid,
   input  logic                          out_stall,
   output qrm_pkg::quat_type             out_quat,
   output logic [qrm_pkg::MagWidth-1:0]  out_mag
);

   logic                   valid_ff [qrm_pkg::SqrtStages];
   logic                   advance  [qrm_pkg::SqrtStages];
   qrm_pkg::quat_type      quat_ff  [qrm_pkg::SqrtStages];
   logic [63:0]            sq_ff    [qrm_pkg::Lanes];
   logic [64:0]            sum_ff;
   qrm_pkg::root_step_type step_ff  [qrm_pkg::SqrtSteps];
   qrm_pkg::root_step_type step_in  [qrm_pkg::SqrtSteps];

   function automatic qrm_pkg::root_step_type root_step(qrm_pkg::root_step_type a);
      qrm_pkg::root_step_type b;
      logic [35:0] r2;
      logic [35:0] trial;
      r2    = {a.rem[33:0], a.rad[63:62]};
      trial = {2'b00, a.root, 2'b01};
      b     = a;
      b.rad = {a.rad[61:0], 2'b00};
      if (r2 >= trial) begin
         b.rem  = r2 - trial;
         b.root = {a.root[30:0], 1'b1};
      end else begin
         b.rem  = r2;
         b.root = {a.root[30:0], 1'b0};
      end
      return b;
   endfunction

   always_comb begin
      advance[qrm_pkg::SqrtStages-1] = !valid_ff[qrm_pkg::SqrtStages-1] || !out_stall;
      for (int i = qrm_pkg::SqrtStages - 2; i >= 0; i--) begin
         advance[i] = !valid_ff[i] || advance[i+1];
      end
   end

   assign in_stall = !advance[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < qrm_pkg::SqrtStages; i++) valid_ff[i] <= 1'b0;
      end else begin
         if (advance[0]) valid_ff[0] <= in_valid;
         for (int i = 1; i < qrm_pkg::SqrtStages; i++) begin
            if (advance[i]) valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance[0]) quat_ff[0] <= in_quat;
      for (int i = 1; i < qrm_pkg::SqrtStages; i++) begin
         if (advance[i]) quat_ff[i] <= quat_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance[0]) begin
         for (int k = 0; k < qrm_pkg::Lanes; k++) begin
            sq_ff[k] <= 64'(qrm_pkg::abs_value(in_quat[k])) *
                        64'(qrm_pkg::abs_value(in_quat[k]));
         end
      end
      if (advance[1]) begin
         sum_ff <= 65'(sq_ff[0]) + 65'(sq_ff[1]) + 65'(sq_ff[2]) + 65'(sq_ff[3]);
      end
   end

   always_comb begin
      step_in[0].rem  = '0;
      step_in[0].root = '0;
      step_in[0].rad  = sum_ff[63:0];
      step_in[0].ovf  = sum_ff[64];
      for (int k = 1; k < qrm_pkg::SqrtSteps; k++) step_in[k] = step_ff[k-1];
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < qrm_pkg::SqrtSteps; k++) begin
         if (advance[k+2]) step_ff[k] <= root_step(step_in[k]);
      end
   end

   assign out_valid = valid_ff[qrm_pkg::SqrtStages-1];
   assign out_quat  = quat_ff[qrm_pkg::SqrtStages-1];
   assign out_mag   = step_ff[qrm_pkg::SqrtSteps-1].ovf ?
                      {1'b1, 32'd0} : {1'b0, step_ff[qrm_pkg::SqrtSteps-1].root};

endmodule
`default_nettype wire

[rtl/qrm_divide.sv]
// Status decision and four-lane restoring divider that normalizes the quaternion when its status is normalized.
// Depends on qrm_pkg.
`default_nettype none
module qrm_divide (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_stall,
   input  qrm_pkg::quat_type             in_quat,
   input  logic [qrm_pkg::MagWidth-1:0]  in_mag,
   input  logic [qrm_pkg::TolWidth-1:0]  tolerance,
   output logic                          out_valid,
   input  logic                          out_stall,
   output qrm_pkg::quat_type             out_quat,
   output logic [1:0]                    out_status
);

   localparam int unsigned MetaStages = qrm_pkg::DivSteps + 1;

   logic                          valid_ff  [qrm_pkg::DivStages];
   logic                          advance   [qrm_pkg::DivStages];
   qrm_pkg::quat_type             quat_ff   [MetaStages];
   logic [qrm_pkg::MagWidth-1:0]  mag_ff    [MetaStages];
   logic [1:0]                    status_ff [MetaStages];
   qrm_pkg::div_lane_type         lane_ff   [MetaStages][qrm_pkg::Lanes];
   qrm_pkg::div_lane_type         lane_init [qrm_pkg::Lanes];
   logic [qrm_pkg::MagWidth-1:0]  dev;
   logic [1:0]                    status_in;
   qrm_pkg::quat_type             quat_out_ff;
   logic [1:0]                    status_out_ff;
   qrm_pkg::quat_type             quat_sel;

   function automatic qrm_pkg::div_lane_type div_step(qrm_pkg::div_lane_type a,
                                                     logic [32:0] mag);
      qrm_pkg::div_lane_type b;
      logic [33:0] r2;
      r2    = {a.rem, a.num[30]};
      b.num = {a.num[29:0], 1'b0};
      if (r2 >= {1'b0, mag}) begin
         b.rem = 33'(r2 - {1'b0, mag});
         b.quo = {a.quo[29:0], 1'b1};
      end else begin
         b.rem = r2[32:0];
         b.quo = {a.quo[29:0], 1'b0};
      end
      return b;
   endfunction

   always_comb begin
      advance[qrm_pkg::DivStages-1] = !valid_ff[qrm_pkg::DivStages-1] || !out_stall;
      for (int i = qrm_pkg::DivStages - 2; i >= 0; i--) begin
         advance[i] = !valid_ff[i] || advance[i+1];
      end
   end

   assign in_stall = !advance[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < qrm_pkg::DivStages; i++) valid_ff[i] <= 1'b0;
      end else begin
         if (advance[0]) valid_ff[0] <= in_valid;
         for (int i = 1; i < qrm_pkg::DivStages; i++) begin
            if (advance[i]) valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   always_comb begin
      logic [61:0] num;
      dev = (in_mag >= qrm_pkg::MagOne) ? (in_mag - qrm_pkg::MagOne)
                                        : (qrm_pkg::MagOne - in_mag);
      if (in_mag == '0) begin
         status_in = qrm_pkg::StatusZero;
      end else if (dev > {2'b00, tolerance}) begin
         status_in = qrm_pkg::StatusNormalized;
      end else begin
         status_in = qrm_pkg::StatusUnit;
      end
      for (int k = 0; k < qrm_pkg::Lanes; k++) begin
         num = {qrm_pkg::abs_value(in_quat[k]), 30'd0} + {30'd0, in_mag[32:1]};
         lane_init[k].rem = {2'b00, num[61:31]};
         lane_init[k].num = num[30:0];
         lane_init[k].quo = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance[0]) begin
         quat_ff[0]   <= in_quat;
         mag_ff[0]    <= in_mag;
         status_ff[0] <= status_in;
         for (int k = 0; k < qrm_pkg::Lanes; k++) lane_ff[0][k] <= lane_init[k];
      end
      for (int i = 1; i < MetaStages; i++) begin
         if (advance[i]) begin
            quat_ff[i]   <= quat_ff[i-1];
            mag_ff[i]    <= mag_ff[i-1];
            status_ff[i] <= status_ff[i-1];
            for (int k = 0; k < qrm_pkg::Lanes; k++) begin
               lane_ff[i][k] <= div_step(lane_ff[i-1][k], mag_ff[i-1]);
            end
         end
      end
   end

   always_comb begin
      logic [30:0] quo;
      logic [31:0] mag32;
      for (int k = 0; k < qrm_pkg::Lanes; k++) begin
         quo   = lane_ff[MetaStages-1][k].quo;
         quo   = (quo > qrm_pkg::QuoOne) ? qrm_pkg::QuoOne : quo;
         mag32 = {1'b0, quo};
         if (status_ff[MetaStages-1] == qrm_pkg::StatusNormalized) begin
            quat_sel[k] = quat_ff[MetaStages-1][k][31] ? (~mag32 + 32'd1) : mag32;
         end else begin
            quat_sel[k] = quat_ff[MetaStages-1][k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance[qrm_pkg::DivStages-1]) begin
         quat_out_ff   <= quat_sel;
         status_out_ff <= status_ff[MetaStages-1];
      end
   end

   assign out_valid  = valid_ff[qrm_pkg::DivStages-1];
   assign out_quat   = quat_out_ff;
   assign out_status = status_out_ff;

endmodule
`default_nettype wire

[rtl/qrm_matrix.sv]
// Products, clamped sums and rounding to the nine Q1.30 matrix entries, all zero for a zero magnitude.
// Depends on qrm_pkg.
`default_nettype none
module qrm_matrix (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_stall,
   input  qrm_pkg::quat_type   in_quat,
   input  logic [1:0]          in_status,
   output logic                out_valid,
   input  logic                out_stall,
   output qrm_pkg::matrix_type out_matrix,
   output logic [1:0]          out_status
);

   localparam int unsigned Prods = 10;

   logic                valid_ff  [qrm_pkg::MatStages];
   logic                advance   [qrm_pkg::MatStages];
   logic [1:0]          status_ff [qrm_pkg::MatStages];
   logic signed [63:0]  prod_ff   [Prods];
   logic signed [62:0]  sum_ff    [qrm_pkg::Entries];
   qrm_pkg::matrix_type out_ff;

   function automatic logic signed [62:0] clamp_sum(logic signed [63:0] a,
                                                    logic signed [63:0] b,
                                                    logic sub);
      logic signed [64:0] t;
      t = sub ? ($signed({a[63], a}) - $signed({b[63], b}))
              : ($signed({a[63], a}) + $signed({b[63], b}));
      if (t > qrm_pkg::SumLimit) t = qrm_pkg::SumLimit;
      if (t < -qrm_pkg::SumLimit) t = -qrm_pkg::SumLimit;
      return t[62:0];
   endfunction

   function automatic logic [31:0] round_entry(logic signed [62:0] v, logic diag);
      logic signed [63:0] w;
      logic signed [63:0] t;
      logic signed [34:0] r;
      w = $signed({v[62], v}) - (diag ? qrm_pkg::DiagBias : 64'sd0);
      t = w + qrm_pkg::RndBias;
      r = t[63:29];
      if (r > qrm_pkg::EntryMax) r = qrm_pkg::EntryMax;
      if (r < qrm_pkg::EntryMin) r = qrm_pkg::EntryMin;
      return r[31:0];
   endfunction

   always_comb begin
      advance[qrm_pkg::MatStages-1] = !valid_ff[qrm_pkg::MatStages-1] || !out_stall;
      for (int i = qrm_pkg::MatStages - 2; i >= 0; i--) begin
         advance[i] = !valid_ff[i] || advance[i+1];
      end
   end

   assign in_stall = !advance[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < qrm_pkg::MatStages; i++) valid_ff[i] <= 1'b0;
      end else begin
         if (advance[0]) valid_ff[0] <= in_valid;
         for (int i = 1; i < qrm_pkg::MatStages; i++) begin
            if (advance[i]) valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   // products: xx yy zz ss xy xz yz sx sy sz
   always_ff @(posedge clock) begin
      if (advance[0]) begin
         status_ff[0] <= in_status;
         prod_ff[0] <= $signed(in_quat[0]) * $signed(in_quat[0]);
         prod_ff[1] <= $signed(in_quat[1]) * $signed(in_quat[1]);
         prod_ff[2] <= $signed(in_quat[2]) * $signed(in_quat[2]);
         prod_ff[3] <= $signed(in_quat[3]) * $signed(in_quat[3]);
         prod_ff[4] <= $signed(in_quat[0]) * $signed(in_quat[1]);
         prod_ff[5] <= $signed(in_quat[0]) * $signed(in_quat[2]);
         prod_ff[6] <= $signed(in_quat[1]) * $signed(in_quat[2]);
         prod_ff[7] <= $signed(in_quat[3]) * $signed(in_quat[0]);
         prod_ff[8] <= $signed(in_quat[3]) * $signed(in_quat[1]);
         prod_ff[9] <= $signed(in_quat[3]) * $signed(in_quat[2]);
      end
      if (advance[1]) begin
         status_ff[1] <= status_ff[0];
         sum_ff[0] <= clamp_sum(prod_ff[3], prod_ff[0], 1'b0);
         sum_ff[1] <= clamp_sum(prod_ff[4], prod_ff[9], 1'b0);
         sum_ff[2] <= clamp_sum(prod_ff[5], prod_ff[8], 1'b1);
         sum_ff[3] <= clamp_sum(prod_ff[4], prod_ff[9], 1'b1);
         sum_ff[4] <= clamp_sum(prod_ff[3], prod_ff[1], 1'b0);
         sum_ff[5] <= clamp_sum(prod_ff[6], prod_ff[7], 1'b0);
         sum_ff[6] <= clamp_sum(prod_ff[5], prod_ff[8], 1'b0);
         sum_ff[7] <= clamp_sum(prod_ff[6], prod_ff[7], 1'b1);
         sum_ff[8] <= clamp_sum(prod_ff[3], prod_ff[2], 1'b0);
      end
      if (advance[2]) begin
         status_ff[2] <= status_ff[1];
         for (int e = 0; e < qrm_pkg::Entries; e++) begin
            if (status_ff[1] == qrm_pkg::StatusZero) begin
               out_ff[e] <= '0;
            end else begin
               out_ff[e] <= round_entry(sum_ff[e], (e == 0) || (e == 4) || (e == 8));
            end
         end
      end
   end

   assign out_valid  = valid_ff[qrm_pkg::MatStages-1];
   assign out_matrix = out_ff;
   assign out_status = status_ff[qrm_pkg::MatStages-1];

endmodule
`default_nettype wire

[rtl/qrm_checker.sv]
// Port-level assertions for the quaternion to rotation matrix unit, bound to the top.
// Depends on qrm_pkg and quaternion_to_rotation_matrix_unit.
`default_nettype none
module qrm_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [31:0] rsp_m00,
   input logic signed [31:0] rsp_m11,
   input logic signed [31:0] rsp_m22,
   input logic signed [31:0] rsp_m01,
   input logic [1:0]         rsp_status
);

   a_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == qrm_pkg::StatusUnit ||
                     rsp_status == qrm_pkg::StatusNormalized ||
                     rsp_status == qrm_pkg::StatusZero))
      else $error("bad status code");

   a_zero_matrix: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == qrm_pkg::StatusZero |->
         rsp_m00 == 0 && rsp_m11 == 0 && rsp_m22 == 0 && rsp_m01 == 0)
      else $error("zero magnitude with nonzero matrix");

   a_saturated: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_m00 <= 32'sh4000_0000 && rsp_m00 >= -32'sh4000_0000 &&
                    rsp_m01 <= 32'sh4000_0000 && rsp_m01 >= -32'sh4000_0000)
      else $error("matrix entry out of range");

endmodule

bind quaternion_to_rotation_matrix_unit qrm_checker u_qrm_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_valid),
   .rsp_stall  (rsp_stall),
   .rsp_m00    (rsp_m00),
   .rsp_m11    (rsp_m11),
   .rsp_m22    (rsp_m22),
   .rsp_m01    (rsp_m01),
   .rsp_status (rsp_status)
);
`default_nettype wire

[dv/quaternion_to_rotation_matrix_unit_test.sv]
// Self-checking testbench for quaternion_to_rotation_matrix_unit: directed and random
// quaternions, tolerance settings, stalls on both channels. Depends on qrm_pkg and the RTL.
`timescale 1ns / 1ps
module quaternion_to_rotation_matrix_unit_test;

   typedef struct {
      logic signed [31:0] m [9];
      logic [1:0]         status;
   } dcm_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [31:0] req_quat_x = '0, req_quat_y = '0, req_quat_z = '0, req_quat_scalar = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [31:0] rsp_m00, rsp_m01, rsp_m02, rsp_m10, rsp_m11, rsp_m12;
   logic signed [31:0] rsp_m20, rsp_m21, rsp_m22;
   logic [1:0]         rsp_status;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [30:0]        csr_norm_tolerance = '0;

   logic [30:0] tolerance = '0;
   dcm_type     expected_dcms [$];
   int          errors = 0;
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          hold_cycles = 0;
   int          quiet_cycles = 0;

   always #1 clock = ~clock;

   quaternion_to_rotation_matrix_unit u_top (.*);

   function automatic logic [63:0] abs64(logic signed [63:0] a);
      return a < 0 ? -a : a;
   endfunction

   function automatic logic signed [63:0] unit_component(logic signed [63:0] q,
                                                         logic [63:0] mag);
      logic [63:0] r;
      r = ((abs64(q) << 30) + (mag >> 1)) / mag;
      if (r > 64'd1073741824) r = 64'd1073741824;
      return q < 0 ? -$signed(r) : $signed(r);
   endfunction

   function automatic logic signed [31:0] round_entry(logic signed [63:0] a,
                                                      logic signed [63:0] b, bit diag);
      logic signed [65:0] s;
      logic signed [65:0] r;
      s = 66'(a) + 66'(b);
      if (s > (66'sd1 <<< 61)) s = 66'sd1 <<< 61;
      if (s < -(66'sd1 <<< 61)) s = -(66'sd1 <<< 61);
      if (diag) s = s - (66'sd1 <<< 59);
      r = (s + (66'sd1 <<< 28)) >>> 29;
      if (r > 66'sd1073741824) r = 66'sd1073741824;
      if (r < -66'sd1073741824) r = -66'sd1073741824;
      return 32'(r);
   endfunction

   function automatic dcm_type predict_dcm(logic signed [31:0] qx, logic signed [31:0] qy,
                                           logic signed [31:0] qz, logic signed [31:0] qs);
      dcm_type d;
      logic signed [63:0] x, y, z, s;
      logic [64:0] sum;
      logic [63:0] mag, c, dev;
      x = qx; y = qy; z = qz; s = qs;
      sum = 65'(abs64(x) * abs64(x)) + 65'(abs64(y) * abs64(y))
          + 65'(abs64(z) * abs64(z)) + 65'(abs64(s) * abs64(s));
      if (sum[64]) mag = 64'd1 << 32;
      else begin
         mag = 0;
         for (int b = 31; b >= 0; b--) begin
            c = mag | (64'd1 << b);
            if (c * c <= sum[63:0]) mag = c;
         end
      end
      if (mag == 0) begin
         foreach (d.m[i]) d.m[i] = '0;
         d.status = qrm_pkg::StatusZero;
         return d;
      end
      dev = mag >= 64'd1073741824 ? mag - 64'd1073741824 : 64'd1073741824 - mag;
      if (dev > 64'(tolerance)) begin
         x = unit_component(x, mag); y = unit_component(y, mag);
         z = unit_component(z, mag); s = unit_component(s, mag);
         d.status = qrm_pkg::StatusNormalized;
      end else d.status = qrm_pkg::StatusUnit;
      d.m[0] = round_entry(s*s, x*x, 1);
      d.m[1] = round_entry(x*y, s*z, 0);
      d.m[2] = round_entry(x*z, -(s*y), 0);
      d.m[3] = round_entry(x*y, -(s*z), 0);
      d.m[4] = round_entry(s*s, y*y, 1);
      d.m[5] = round_entry(y*z, s*x, 0);
      d.m[6] = round_entry(x*z, s*y, 0);
      d.m[7] = round_entry(y*z, -(s*x), 0);
      d.m[8] = round_entry(s*s, z*z, 1);
      return d;
   endfunction

   task automatic send_quat(logic signed [31:0] x, logic signed [31:0] y,
                            logic signed [31:0] z, logic signed [31:0] s);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_quat_x      <= x;
      req_quat_y      <= y;
      req_quat_z      <= z;
      req_quat_scalar <= s;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_dcms.insert(expected_dcms.size(), predict_dcm(x, y, z, s));
   endtask

   task automatic drain_and_idle();
      while (expected_dcms.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_tolerance(logic [30:0] t);
      drain_and_idle();
      csr_valid          <= 1'b1;
      csr_norm_tolerance <= t;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      tolerance = t;
   endtask

   function automatic logic signed [31:0] rand_field();
      case ($urandom_range(5, 0))
         0: return $urandom_range(1, 0) ? 32'sh4000_0000 : -32'sh4000_0000;
         1: return $signed(32'h8000_0000 | $urandom_range(3, 0));
         2: return 32'sh7FFF_FFFF - $urandom_range(3, 0);
         3: return $signed(32'($urandom_range(2048, 0)) - 32'sd1024);
         default: return $signed($urandom());
      endcase
   endfunction

   task automatic test_directed();
      logic signed [31:0] one = 32'sh4000_0000;
      logic signed [31:0] half = 32'sh2000_0000;
      send_quat(0, 0, 0, 0);
      send_quat(0, 0, 0, one);
      send_quat(one, 0, 0, 0);
      send_quat(0, one, 0, 0);
      send_quat(0, 0, one, 0);
      send_quat(0, 0, 0, -one);
      send_quat(half, half, half, half);
      send_quat(-half, half, -half, half);
      send_quat(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
      send_quat(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
      send_quat(32'sh8000_0000, 0, 0, 0);
      send_quat(0, 0, 0, 1);
      send_quat(1, -1, 1, -1);
      send_quat(0, 0, 0, one + 1);
      send_quat(0, 0, 0, one - 1);
      send_quat(32'sh7FFF_FFFF, 0, 0, 32'sh8000_0000);
      send_quat(-1, -1, -1, -1);
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_random(int count);
      logic signed [31:0] x, y, z, s;
      int k;
      for (int i = 0; i < count; i++) begin
         k = $urandom_range(3, 0);
         if (k == 0) send_quat(rand_field(), rand_field(), rand_field(), rand_field());
         else begin
            // random quaternion, components at most one, magnitude up to about 1.25
            x = $signed(32'($urandom_range(32'h3FFF_FFFF, 0))) >>> $urandom_range(3, 0);
            y = $signed(32'($urandom_range(32'h3FFF_FFFF, 0))) >>> $urandom_range(3, 1);
            z = $signed(32'($urandom_range(32'h1FFF_FFFF, 0))) >>> 1;
            s = $signed(32'($urandom_range(32'h1FFF_FFFF, 0)));
            if ($urandom_range(1, 0)) x = -x;
            if ($urandom_range(1, 0)) y = -y;
            if ($urandom_range(1, 0)) z = -z;
            if ($urandom_range(1, 0)) s = -s;
            send_quat(x, y, z, s);
         end
      end
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_backpressure();
      hold_cycles = 300;
      test_random(150);
      while (hold_cycles != 0) @(posedge clock);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      write_tolerance(31'h4000_0000);
      test_directed();
      write_tolerance(31'd0);
      send_idle_pct = 9; recv_idle_pct = 74;
      test_random(600);
      write_tolerance(31'd1 << 20);
      send_idle_pct = 74; recv_idle_pct = 9;
      test_random(500);
      write_tolerance(31'h7FFF_FFFF);
      send_idle_pct = 0; recv_idle_pct = 0;
      test_random(300);
      test_backpressure();
      write_tolerance(31'd3);
      test_random(250);
      drain_and_idle();
      if (errors == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

   always @(posedge clock) begin
      if (hold_cycles != 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall   <= 1'b1;
      end else rsp_stall <= ($urandom_range(99, 0) < recv_idle_pct);
   end

   always @(posedge clock) begin
      dcm_type e;
      logic signed [31:0] got [9];
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_m00, rsp_m01, rsp_m02, rsp_m10, rsp_m11, rsp_m12,
                 rsp_m20, rsp_m21, rsp_m22};
         if (expected_dcms.size() == 0) begin
            $display("%0t: unexpected response", $time);
            errors++;
         end else begin
            e = expected_dcms.pop_front();
            foreach (got[i])
               if (got[i] !== e.m[i]) begin
                  $display("%0t: m[%0d] expected %0d actual %0d", $time, i, e.m[i], got[i]);
                  errors++;
               end
            if (rsp_status !== e.status) begin
               $display("%0t: status expected %0d actual %0d", $time, e.status, rsp_status);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_valid || reset)
         quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 5000) begin
         $display("*** FAILED ***");
         $finish;
      end
   end
endmodule
